### sv/tcw_pkg.sv
// ============================================================================
// tcw_pkg: text console writer shared types and constants
// Request/response payloads, microcode word layout and fixed geometry.
// ============================================================================
`default_nettype none

package tcw_pkg;

    // Video memory geometry (fixed by the 13-bit cell fields)
    localparam int CELLS   = 8192;
    localparam int CELL_AW = $clog2(CELLS);

    localparam logic [15:0] RESET_CELL = 16'h0720;
    localparam logic [7:0]  RESET_ATTR = 8'h07;

    // Request opcodes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Control bytes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_HT  = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Configuration register indexes
    localparam logic CFG_ATTR  = 1'b0;
    localparam logic CFG_BLANK = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic        end_of_write;
        logic [12:0] cell_address;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [12:0] cursor_cell;
        logic [12:0] screen_start;
        logic        beep;
    } rsp_t;

    // Microcode addresses
    typedef enum logic [3:0] {
        U_INIT,
        U_IDLE,
        U_READ,
        U_READ_DATA,
        U_CLEAR,
        U_BS,
        U_DEL,
        U_CR,
        U_WRAP,
        U_PUT,
        U_NL,
        U_SCROLL,
        U_BLANK,
        U_COPY,
        U_DONE
    } uaddr_t;

    // Datapath action of one step
    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_FILL_RST,
        A_FILL_BLANK,
        A_RD_ISSUE,
        A_RD_CAPTURE,
        A_BS,
        A_DEL,
        A_CR,
        A_WRAP,
        A_PUT,
        A_NL,
        A_COPY,
        A_BLANK_ROW,
        A_RESULT
    } act_t;

    // Loop bound for the step counter
    typedef enum logic [1:0] {
        LIM_NONE,
        LIM_CELLS,
        LIM_SCREEN,
        LIM_COLS
    } lim_t;

    // Next-address selection
    typedef enum logic [2:0] {
        SQ_JUMP,
        SQ_LOOP,
        SQ_LOOP_RET,
        SQ_DISPATCH,
        SQ_NL,
        SQ_COND,
        SQ_OUT
    } seq_t;

    typedef struct packed {
        act_t   act;
        lim_t   lim;
        seq_t   seq;
        uaddr_t target;
        uaddr_t alt;
    } ctrl_t;

    // Datapath conditions fed back to the sequencer
    typedef struct packed {
        logic   accept;
        uaddr_t disp;
        uaddr_t disp_ret;
        logic   loop_done;
        logic   nl_stay;
        logic   near_end;
        logic   out_free;
    } status_t;

endpackage

`default_nettype wire

### sv/tcw_ram.sv
// ============================================================================
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ============================================================================
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/tcw_useq.sv
// ============================================================================
// tcw_useq: microcode sequencer
// Holds the microcode address and return address, reads the control ROM.
// ============================================================================
`default_nettype none

module tcw_useq
    import tcw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t st,
    output      ctrl_t   ctrl
);

    uaddr_t upc_reg, upc_next;
    uaddr_t ret_reg, ret_next;

    // next step
    always_comb
    begin
        upc_next = upc_reg;
        ret_next = ret_reg;
        case (ctrl.seq)
            SQ_JUMP:     upc_next = ctrl.target;
            SQ_LOOP:     upc_next = st.loop_done ? ctrl.target : upc_reg;
            SQ_LOOP_RET: upc_next = st.loop_done ? ret_reg : upc_reg;
            SQ_DISPATCH:
            begin
                if (st.accept)
                begin
                    upc_next = st.disp;
                    ret_next = st.disp_ret;
                end
            end
            SQ_NL:       upc_next = st.nl_stay ? ret_reg : ctrl.target;
            SQ_COND:     upc_next = st.near_end ? ctrl.target : ctrl.alt;
            SQ_OUT:      upc_next = st.out_free ? ctrl.target : upc_reg;
            default:     upc_next = U_IDLE;
        endcase
    end

    // control ROM: act, loop bound, sequencing, target, alternative
    always_comb
    begin
        case (upc_reg)
            U_INIT:      ctrl = '{A_FILL_RST,   LIM_CELLS,  SQ_LOOP,     U_IDLE,      U_IDLE};
            U_IDLE:      ctrl = '{A_ACCEPT,     LIM_NONE,   SQ_DISPATCH, U_IDLE,      U_IDLE};
            U_READ:      ctrl = '{A_RD_ISSUE,   LIM_NONE,   SQ_JUMP,     U_READ_DATA, U_IDLE};
            U_READ_DATA: ctrl = '{A_RD_CAPTURE, LIM_NONE,   SQ_JUMP,     U_DONE,      U_IDLE};
            U_CLEAR:     ctrl = '{A_FILL_BLANK, LIM_CELLS,  SQ_LOOP,     U_DONE,      U_IDLE};
            U_BS:        ctrl = '{A_BS,         LIM_NONE,   SQ_JUMP,     U_DONE,      U_IDLE};
            U_DEL:       ctrl = '{A_DEL,        LIM_NONE,   SQ_JUMP,     U_DONE,      U_IDLE};
            U_CR:        ctrl = '{A_CR,         LIM_NONE,   SQ_JUMP,     U_DONE,      U_IDLE};
            U_WRAP:      ctrl = '{A_WRAP,       LIM_NONE,   SQ_JUMP,     U_NL,        U_IDLE};
            U_PUT:       ctrl = '{A_PUT,        LIM_NONE,   SQ_JUMP,     U_DONE,      U_IDLE};
            U_NL:        ctrl = '{A_NL,         LIM_NONE,   SQ_NL,       U_SCROLL,    U_IDLE};
            U_SCROLL:    ctrl = '{A_NONE,       LIM_NONE,   SQ_COND,     U_COPY,      U_BLANK};
            U_BLANK:     ctrl = '{A_BLANK_ROW,  LIM_COLS,   SQ_LOOP_RET, U_IDLE,      U_IDLE};
            U_COPY:      ctrl = '{A_COPY,       LIM_SCREEN, SQ_LOOP,     U_BLANK,     U_IDLE};
            U_DONE:      ctrl = '{A_RESULT,     LIM_NONE,   SQ_OUT,      U_IDLE,      U_IDLE};
            default:     ctrl = '{A_NONE,       LIM_NONE,   SQ_JUMP,     U_IDLE,      U_IDLE};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_INIT;
            ret_reg <= U_DONE;
        end
        else
        begin
            upc_reg <= upc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

`default_nettype wire

### sv/text_console_writer_core.sv
// ============================================================================
// text_console_writer_core: text console writer with its own video memory
// Takes bytes, control codes, cell reads and clears; scrolls the screen.
// ============================================================================
//
//  channel | signals                     | dir | moves
//  --------+-----------------------------+-----+--------------------------------
//  req     | req_valid, req_stall, req   | in  | one request (op, byte, eow, addr)
//  rsp     | rsp_valid, rsp_stall, rsp   | out | one response per request
//  cfg     | cfg_valid, cfg_ready,       | in  | register write, always ready
//          | cfg_index, cfg_data         |     |
//
//  Steps per request (from acceptance to response loaded): printable byte,
//  BS, DEL, CR: their action step, then U_DONE; read: U_READ, U_READ_DATA,
//  U_DONE; new line: U_NL (LF adds U_CR); a column wrap adds U_WRAP and U_NL;
//  a scroll adds U_SCROLL and U_BLANK, with U_COPY first when the screen is
//  copied back to cell 0; clear: U_CLEAR over every cell. The single video
//  memory port pair sets every loop length. After reset a fill pass writes
//  0x0720 to every cell; no request is taken meanwhile, configuration writes are.
//  A response waiting under rsp_stall does not block the next request; it
//  only holds the following one at its final step.
// ============================================================================
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        req_valid,
    output      logic        req_stall,
    input  wire req_t        req,
    // response channel
    output      logic        rsp_valid,
    input  wire logic        rsp_stall,
    output      rsp_t        rsp,
    // configuration write channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int SCREEN = COLUMNS * ROWS;
    localparam int CNT_MAX = (SCREEN > CELLS) ? SCREEN : CELLS;
    localparam int CW     = $clog2(CNT_MAX + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int NW     = $clog2(CELLS + SCREEN + COLUMNS + 1);

    // row and screen sizes as cell offsets (modulo memory size)
    localparam logic [CELL_AW-1:0] COLS_A   = CELL_AW'(COLUMNS % CELLS);
    localparam logic [CELL_AW-1:0] SCREEN_A = CELL_AW'(SCREEN % CELLS);

    ctrl_t   ctrl;
    status_t st;

    // console state
    logic [CELL_AW-1:0] sb_reg, sb_next;          // screen base
    logic [CELL_AW-1:0] wp_reg, wp_next;          // write position
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [CELL_AW-1:0] cursor_reg, cursor_next;
    logic [7:0]         attr_reg, attr_next;
    logic [15:0]        blank_reg, blank_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    // held request and response
    req_t               item_reg, item_next;
    logic [15:0]        rd_reg, rd_next;
    rsp_t               rsp_reg, rsp_next;
    logic               out_valid_reg, out_valid_next;

    // memory port
    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    logic [15:0]        mem_wdata;
    logic               mem_re;
    logic [CELL_AW-1:0] mem_raddr;
    logic [15:0]        mem_rdata;

    logic [CW-1:0]      cnt_last;
    logic               load;

    tcw_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_vram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_stall = (ctrl.act != A_ACCEPT);
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    // loop bound of the current step
    always_comb
    begin
        case (ctrl.lim)
            LIM_CELLS:  cnt_last = CW'(CELLS - 1);
            LIM_SCREEN: cnt_last = CW'(SCREEN);
            LIM_COLS:   cnt_last = CW'(COLUMNS - 1);
            default:    cnt_last = '0;
        endcase
    end

    // status back to the sequencer, including request dispatch
    always_comb
    begin
        st.accept    = req_valid && (ctrl.act == A_ACCEPT);
        st.loop_done = (cnt_reg == cnt_last);
        st.nl_stay   = (row_reg != ROW_W'(ROWS - 1));
        st.near_end  = ({{(NW - CELL_AW){1'b0}}, sb_reg} + NW'(SCREEN + COLUMNS))
                       >= NW'(CELLS);
        st.out_free  = !out_valid_reg || !rsp_stall;
        st.disp      = U_DONE;
        st.disp_ret  = U_DONE;
        case (req.op)
            OP_PUT:
            begin
                case (req.char_code)
                    CH_NUL, CH_ENQ, CH_ESC, CH_HT, CH_VT, CH_BEL: st.disp = U_DONE;
                    CH_BS:  st.disp = U_BS;
                    CH_DEL: st.disp = U_DEL;
                    CH_CR:  st.disp = U_CR;
                    CH_LF:
                    begin
                        st.disp     = U_NL;
                        st.disp_ret = U_CR;
                    end
                    CH_FF:  st.disp = U_NL;
                    default:
                    begin
                        // past the last column: wrap before storing
                        if (col_reg == COL_W'(COLUMNS))
                        begin
                            st.disp     = U_WRAP;
                            st.disp_ret = U_PUT;
                        end
                        else
                        begin
                            st.disp = U_PUT;
                        end
                    end
                endcase
            end
            OP_READ:  st.disp = U_READ;
            OP_CLEAR: st.disp = U_CLEAR;
            default:  st.disp = U_DONE;
        endcase
    end

    // datapath driven by the control word
    always_comb
    begin
        sb_next     = sb_reg;
        wp_next     = wp_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cursor_next = cursor_reg;
        attr_next   = attr_reg;
        blank_next  = blank_reg;
        item_next   = item_reg;
        rd_next     = rd_reg;
        rsp_next    = rsp_reg;
        load        = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = wp_reg;
        mem_wdata   = blank_reg;
        mem_re      = 1'b0;
        mem_raddr   = item_reg.cell_address;

        case (ctrl.act)
            A_ACCEPT:
            begin
                if (req_valid)
                begin
                    item_next = req;
                end
            end
            A_FILL_RST:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[CELL_AW-1:0];
                mem_wdata = RESET_CELL;
            end
            A_FILL_BLANK:
            begin
                mem_we      = 1'b1;
                mem_waddr   = cnt_reg[CELL_AW-1:0];
                sb_next     = '0;
                wp_next     = '0;
                col_next    = '0;
                row_next    = '0;
                cursor_next = '0;
            end
            A_RD_ISSUE:
            begin
                mem_re = 1'b1;
            end
            A_RD_CAPTURE:
            begin
                rd_next = mem_rdata;
            end
            A_BS:
            begin
                // nothing at column 0
                if (col_reg != '0)
                begin
                    col_next  = col_reg - 1'b1;
                    wp_next   = wp_reg - 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = wp_reg - 1'b1;
                end
            end
            A_DEL:
            begin
                mem_we = 1'b1;
            end
            A_CR:
            begin
                wp_next  = wp_reg - CELL_AW'(col_reg);
                col_next = '0;
            end
            A_WRAP:
            begin
                col_next = col_reg - COL_W'(COLUMNS);
                wp_next  = wp_reg - COLS_A;
            end
            A_PUT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {attr_reg, item_reg.char_code};
                wp_next   = wp_reg + 1'b1;
                col_next  = col_reg + 1'b1;
            end
            A_NL:
            begin
                if (st.nl_stay)
                begin
                    row_next = row_reg + 1'b1;
                    wp_next  = wp_reg + COLS_A;
                end
            end
            A_COPY:
            begin
                // read one ahead, write the cell read last step
                mem_re    = 1'b1;
                mem_raddr = sb_reg + cnt_reg[CELL_AW-1:0];
                mem_wdata = mem_rdata;
                mem_waddr = cnt_reg[CELL_AW-1:0] - 1'b1;
                mem_we    = (cnt_reg != '0);
                if (st.loop_done)
                begin
                    wp_next = wp_reg - sb_reg;
                    sb_next = '0;
                end
            end
            A_BLANK_ROW:
            begin
                mem_we    = 1'b1;
                mem_waddr = sb_reg + SCREEN_A + cnt_reg[CELL_AW-1:0];
                if (st.loop_done)
                begin
                    sb_next = sb_reg + COLS_A;
                    wp_next = wp_reg + COLS_A;
                end
            end
            A_RESULT:
            begin
                if (st.out_free)
                begin
                    load = 1'b1;
                    if ((item_reg.op == OP_PUT) && item_reg.end_of_write)
                    begin
                        cursor_next = wp_reg;
                    end
                    rsp_next.read_data    = (item_reg.op == OP_READ) ? rd_reg : '0;
                    rsp_next.cursor_cell  = cursor_next;
                    rsp_next.screen_start = sb_reg;
                    rsp_next.beep         = (item_reg.op == OP_PUT)
                                            && (item_reg.char_code == CH_BEL);
                end
            end
            default:
            begin
            end
        endcase

        // configuration writes land at any time
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ATTR:  attr_next  = cfg_data[7:0];
                CFG_BLANK: blank_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // step counter
    always_comb
    begin
        if (ctrl.lim == LIM_NONE || st.loop_done)
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign out_valid_next = load || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg        <= '0;
            wp_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cursor_reg    <= '0;
            attr_reg      <= RESET_ATTR;
            blank_reg     <= RESET_CELL;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sb_reg        <= sb_next;
            wp_reg        <= wp_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cursor_reg    <= cursor_next;
            attr_reg      <= attr_next;
            blank_reg     <= blank_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rd_reg   <= rd_next;
        rsp_reg  <= rsp_next;
    end

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(COLUMNS))
        else $error("column past end of row");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(ROWS - 1))
        else $error("row past last screen row");

    a_copy_base: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == A_COPY && !st.loop_done) |=> $stable(sb_reg))
        else $error("screen base moved during copy-back");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == A_FILL_BLANK && st.loop_done)
        |=> (sb_reg == '0 && wp_reg == '0 && cursor_reg == '0 && col_reg == '0))
        else $error("console not homed after clear");

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for text_console_writer_core
// Drives byte streams, cell reads and clears under random request gaps and
// response stalls, mirrors the console state and compares every response.
// ============================================================================

module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int SCREEN_CELLS = COLUMNS * ROWS;

    // op code left unused by the block
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 200;
    localparam int TAIL_START   = 1080;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        CALL_MIXED,
        CALL_LINES,
        CALL_LONG
    } call_kind_t;

    // ------------------------------------------------------------------------
    // Console mirror: own copy of video memory, cursor state and registers.
    // Every accepted request is applied here and its response queued.
    // ------------------------------------------------------------------------
    class console_mirror;
        logic [15:0] vram [CELLS];
        int unsigned screen_base;
        int unsigned column;
        int unsigned row;
        logic [12:0] write_pos;
        logic [12:0] cursor;
        logic [7:0]  attr;
        logic [15:0] blank;
        rsp_t        replies_due [$];
        int          errors;

        function new();
            foreach (vram[i])
                vram[i] = RESET_CELL;
            screen_base = 0;
            column      = 0;
            row         = 0;
            write_pos   = '0;
            cursor      = '0;
            attr        = RESET_ATTR;
            blank       = RESET_CELL;
            errors      = 0;
        endfunction

        function void set_register(logic idx, logic [15:0] value);
            if (idx == CFG_ATTR)
                attr = value[7:0];
            else
                blank = value;
        endfunction

        // Last row reached: copy the screen back to cell 0 when the buffer
        // is near its end, then blank the row below and advance one row.
        function void scroll_row();
            if (screen_base + SCREEN_CELLS + COLUMNS >= CELLS) begin
                for (int i = 0; i < SCREEN_CELLS; i++)
                    vram[i % CELLS] = vram[(screen_base + i) % CELLS];
                write_pos   = write_pos - 13'(screen_base);
                screen_base = 0;
            end
            for (int i = 0; i < COLUMNS; i++)
                vram[(screen_base + SCREEN_CELLS + i) % CELLS] = blank;
            screen_base += COLUMNS;
            write_pos    = write_pos + 13'(COLUMNS);
        endfunction

        function void new_line();
            if (row + 1 < ROWS) begin
                row++;
                write_pos = write_pos + 13'(COLUMNS);
            end
            else
                scroll_row();
        endfunction

        function void carriage_return();
            write_pos = write_pos - 13'(column);
            column    = 0;
        endfunction

        function void apply_request(req_t r);
            rsp_t want;
            want = '0;
            case (r.op)
                OP_PUT:
                begin
                    case (r.char_code)
                        CH_NUL, CH_ENQ, CH_ESC, CH_HT, CH_VT: ;
                        CH_BEL: want.beep = 1'b1;
                        CH_BS:
                        begin
                            if (column != 0) begin
                                column--;
                                write_pos       = write_pos - 13'd1;
                                vram[write_pos] = blank;
                            end
                        end
                        CH_LF:
                        begin
                            new_line();
                            carriage_return();
                        end
                        CH_FF:  new_line();
                        CH_CR:  carriage_return();
                        CH_DEL: vram[write_pos] = blank;
                        default:
                        begin
                            // deferred wrap: only at the next printable byte
                            if (column >= COLUMNS) begin
                                column   -= COLUMNS;
                                write_pos = write_pos - 13'(COLUMNS);
                                new_line();
                            end
                            vram[write_pos] = {attr, r.char_code};
                            write_pos       = write_pos + 13'd1;
                            column++;
                        end
                    endcase
                    if (r.end_of_write)
                        cursor = write_pos;
                end
                OP_READ:
                    want.read_data = vram[r.cell_address];
                OP_CLEAR:
                begin
                    screen_base = 0;
                    write_pos   = '0;
                    column      = 0;
                    row         = 0;
                    cursor      = '0;
                    foreach (vram[i])
                        vram[i] = blank;
                end
                default: ;
            endcase
            want.cursor_cell  = cursor;
            want.screen_start = 13'(screen_base);
            replies_due.push_back(want);
        endfunction

        function void compare_reply(rsp_t got);
            rsp_t want;
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: response with no request outstanding: rd=%h cur=%h ss=%h beep=%b",
                             $time, got.read_data, got.cursor_cell, got.screen_start, got.beep);
                return;
            end
            want = replies_due.pop_front();
            if (got.read_data    !== want.read_data   ||
                got.cursor_cell  !== want.cursor_cell ||
                got.screen_start !== want.screen_start ||
                got.beep         !== want.beep) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: mismatch want rd=%h cur=%h ss=%h beep=%b got rd=%h cur=%h ss=%h beep=%b",
                             $time, want.read_data, want.cursor_cell, want.screen_start,
                             want.beep, got.read_data, got.cursor_cell, got.screen_start,
                             got.beep);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_ATTR;
    logic [15:0] cfg_data  = '0;

    console_mirror mirror;

    int  work_items  = 0;     // requests that do real work (ignored ones excluded)
    int  req_gap_pct = 20;    // chance of a request gap after each request
    int  stall_pct   = 20;    // chance of starting a response stall burst
    int  stall_left  = 0;
    int  clears_left = 3;     // clears are slow: keep them few in the random part
    bit  quiet_tail  = 1'b0;  // no idling on either side near the end

    logic [7:0] idle_codes [5] = '{CH_NUL, CH_ENQ, CH_ESC, CH_HT, CH_VT};

    always #2 clk = ~clk;

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Response side back-pressure: stall bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0)
                rsp_stall <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 7);
        end
    end

    // Response monitor: every accepted response against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            mirror.compare_reply(rsp);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic req_t make_req(logic [1:0] op, logic [7:0] ch, logic eow,
                                      logic [12:0] addr);
        req_t r;
        r.op           = op;
        r.char_code    = ch;
        r.end_of_write = eow;
        r.cell_address = addr;
        return r;
    endfunction

    // unused fields still toggle: start every request from random bits
    function automatic req_t random_req();
        return make_req(2'($urandom), 8'($urandom), 1'($urandom), 13'($urandom));
    endfunction

    function automatic logic [7:0] printable_byte();
        logic [7:0] b;
        bit         ctl;
        do begin
            b = 8'($urandom);
            case (b)
                CH_NUL, CH_ENQ, CH_BEL, CH_BS, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR,
                CH_ESC, CH_DEL: ctl = 1'b1;
                default:        ctl = 1'b0;
            endcase
        end while (ctl);
        return b;
    endfunction

    function automatic logic [7:0] next_byte(call_kind_t kind);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (kind)
            CALL_LINES:
                return (r < 50) ? CH_LF : (r < 70) ? CH_FF : printable_byte();
            CALL_LONG:
                return (r < 95) ? printable_byte() : (r < 98) ? CH_LF : CH_BS;
            default:
            begin
                if (r < 52) return printable_byte();
                if (r < 70) return CH_LF;
                if (r < 78) return CH_FF;
                if (r < 84) return CH_CR;
                if (r < 89) return CH_BS;
                if (r < 92) return CH_DEL;
                if (r < 95) return CH_BEL;
                return idle_codes[$urandom_range(0, 4)];
            end
        endcase
    endfunction

    // Offer one request, hold it until taken, note it in the mirror.
    // Valid stays high into the next request unless a gap is drawn.
    task automatic issue(req_t r);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        mirror.apply_request(r);
        case (r.op)
            OP_SPARE: ;
            OP_PUT:
                case (r.char_code)
                    CH_NUL, CH_ENQ, CH_ESC, CH_HT, CH_VT: ;
                    default: work_items++;
                endcase
            default: work_items++;
        endcase
        if (!quiet_tail && $urandom_range(0, 99) < req_gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding response
    task automatic settle();
        req_valid <= 1'b0;
        while (mirror.replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Both registers in one burst; upper byte of the attribute write is junk
    task automatic program_registers(logic [7:0] attr, logic [15:0] blank);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ATTR;
        cfg_data  <= {8'($urandom), attr};
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror.set_register(CFG_ATTR, cfg_data);
        cfg_index <= CFG_BLANK;
        cfg_data  <= blank;
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror.set_register(CFG_BLANK, blank);
        cfg_valid <= 1'b0;
    endtask

    // One write call: a run of bytes, normally closed by end_of_write.
    // Mixed calls exercise control codes, line calls push towards scrolling
    // and the copy-back, long calls force column wraps.
    task automatic write_call();
        call_kind_t kind;
        int         pick;
        int         len;
        req_t       r;
        pick = $urandom_range(0, 99);
        kind = (pick < 55) ? CALL_MIXED : (pick < 85) ? CALL_LINES : CALL_LONG;
        case (kind)
            CALL_LONG:  len = $urandom_range(60, 130);
            CALL_LINES: len = $urandom_range(4, 24);
            default:    len = $urandom_range(1, 16);
        endcase
        // in a quarter of calls each side, drawn apart, runs with no idling at all
        req_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
        stall_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
        for (int i = 0; i < len; i++) begin
            r              = random_req();
            r.op           = OP_PUT;
            r.char_code    = next_byte(kind);
            r.end_of_write = (i == len - 1) ? ($urandom_range(0, 19) != 0)
                                            : ($urandom_range(0, 19) == 0);
            issue(r);
            quiet_tail = (work_items >= TAIL_START);
        end
    endtask

    // Reads between calls, now and then a spare op or a clear
    task automatic stray_requests();
        int   pick;
        req_t r;
        repeat ($urandom_range(1, 3)) begin
            r    = random_req();
            pick = $urandom_range(0, 99);
            if (pick < 6)
                r.op = OP_SPARE;
            else if (pick < 9 && clears_left > 0) begin
                r.op = OP_CLEAR;
                clears_left--;
            end
            else begin
                r.op = OP_READ;
                if (pick < 45)
                    r.cell_address = mirror.write_pos + 13'($urandom_range(0, 180)) - 13'd90;
                else if (pick < 70)
                    r.cell_address = 13'(mirror.screen_base) +
                                     13'($urandom_range(0, SCREEN_CELLS + COLUMNS - 1));
            end
            issue(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mirror = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // written during the clearing pass, which still takes register writes
        program_registers(8'hFF, 16'h0000);

        // directed requests: field extremes, every op and control code
        issue(make_req(OP_READ, 8'h00, 1'b0, 13'd0));
        issue(make_req(OP_READ, 8'hFF, 1'b1, 13'h1FFF));
        issue(make_req(OP_PUT, 8'h41, 1'b0, 13'h1FFF));
        issue(make_req(OP_PUT, 8'hFF, 1'b1, 13'd0));
        issue(make_req(OP_PUT, CH_BEL, 1'b0, 13'd0));
        issue(make_req(OP_PUT, CH_NUL, 1'b1, 13'd0));
        issue(make_req(OP_PUT, CH_ENQ, 1'b0, 13'd0));
        issue(make_req(OP_PUT, CH_ESC, 1'b0, 13'd0));
        issue(make_req(OP_PUT, CH_HT, 1'b0, 13'd0));
        issue(make_req(OP_PUT, CH_VT, 1'b1, 13'd0));
        issue(make_req(OP_PUT, CH_BS, 1'b1, 13'd0));
        issue(make_req(OP_PUT, CH_DEL, 1'b0, 13'd0));
        issue(make_req(OP_READ, 8'h00, 1'b0, 13'd1));
        issue(make_req(OP_PUT, 8'h20, 1'b0, 13'd0));
        issue(make_req(OP_PUT, 8'h01, 1'b1, 13'd0));
        issue(make_req(OP_PUT, CH_CR, 1'b1, 13'd0));
        // backspace at column 0 must leave everything alone
        issue(make_req(OP_PUT, CH_BS, 1'b1, 13'd0));
        issue(make_req(OP_PUT, CH_LF, 1'b1, 13'd0));
        issue(make_req(OP_PUT, CH_FF, 1'b1, 13'd0));
        // spare op carrying a BEL byte: no beep, no state change
        issue(make_req(OP_SPARE, CH_BEL, 1'b1, 13'h1555));
        issue(make_req(OP_READ, 8'h00, 1'b0, 13'd0));
        issue(make_req(OP_CLEAR, 8'h00, 1'b0, 13'd0));
        issue(make_req(OP_READ, 8'h00, 1'b0, 13'h1ABC));
        issue(make_req(OP_PUT, 8'h80, 1'b1, 13'd0));
        issue(make_req(OP_READ, 8'h00, 1'b0, 13'd0));
        settle();

        // random part: register settings change only between phases, when idle
        work_items = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       program_registers(8'h00, 16'hFFFF);
                1:       program_registers(8'hFF, 16'h0000);
                default: program_registers(8'($urandom), 16'($urandom));
            endcase
            while (work_items < (phase + 1) * PHASE_ITEMS) begin
                write_call();
                if ($urandom_range(0, 99) < 40)
                    stray_requests();
            end
            settle();
        end

        // let any stray response show up before the verdict
        repeat (40) @(posedge clk);
        if (mirror.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the clearing pass
    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_useq.sv
sv/text_console_writer_core.sv
verif/testbench.sv
